@@ hdl/jet_pkg.sv @@
// ----------------------------------------------------------------------------
// jet_pkg: Julia escape-time pixel unit package
// Types, constants and fixed-point helpers shared by the pixel unit files.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int unsigned IMAGE_WIDTH  = 1024;
  localparam int unsigned IMAGE_HEIGHT = 1024;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned ITER_W  = 11;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 3;

  localparam logic [ITER_W-1:0] ITER_CAP = ITER_W'(1024);

  // image size holds up to 4096, the half of it up to 2048
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned DIFF_W = 14;
  localparam int unsigned MAG_W  = 14;
  localparam int unsigned FRAC_SHIFT = 44;
  localparam int unsigned NUM_W  = MAG_W + FRAC_SHIFT;
  localparam int unsigned DEN_W  = DATA_W + DIM_W;
  localparam int unsigned CNT_W  = $clog2(NUM_W + 1);

  localparam logic [DIFF_W-1:0] HALF_W = DIFF_W'(IMAGE_WIDTH / 2);
  localparam logic [DIFF_W-1:0] HALF_H = DIFF_W'(IMAGE_HEIGHT / 2);
  localparam logic [DIM_W-1:0]  SIZE_W = DIM_W'(IMAGE_WIDTH);
  localparam logic [DIM_W-1:0]  SIZE_H = DIM_W'(IMAGE_HEIGHT);
  localparam logic [1:0]        SCALE_RE = 2'd3;
  localparam logic [1:0]        SCALE_IM = 2'd2;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic [63:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

  localparam logic [IDX_W-1:0] REG_ZOOM        = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_REAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET_IMAG = 3'd2;
  localparam logic [IDX_W-1:0] REG_C_REAL      = 3'd3;
  localparam logic [IDX_W-1:0] REG_C_IMAG      = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_ITER    = 3'd5;

  localparam logic [DATA_W-1:0] ZOOM_RST     = 32'd65536;
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 11'd256;

  typedef struct packed {
    logic [DATA_W-1:0]        zoom;
    logic signed [DATA_W-1:0] offset_real;
    logic signed [DATA_W-1:0] offset_imag;
    logic signed [DATA_W-1:0] c_real;
    logic signed [DATA_W-1:0] c_imag;
    logic [ITER_W-1:0]        max_iterations;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [ITER_W-1:0]  iteration_count;
    logic               escaped;
  } res_t;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
  } map_num_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_SQR,
    ST_SQI,
    ST_CHK,
    ST_RI,
    ST_NIM,
    ST_DONE
  } st_t;

  typedef enum logic [1:0] {
    MUL_RE_IM,
    MUL_RE_RE,
    MUL_IM_IM
  } mul_sel_t;

  // sign and magnitude numerator of scale * (pix - half) * 2^44
  function automatic map_num_t map_num(input logic [COORD_W-1:0] pix,
                                       input logic [DIFF_W-1:0] half,
                                       input logic [1:0] scale);
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] absd;
    logic [MAG_W-1:0]  mag;
    map_num_t          r;
    d     = DIFF_W'(pix) - half;
    absd  = d[DIFF_W-1] ? (DIFF_W'(0) - d) : d;
    mag   = MAG_W'(absd * scale);
    r.neg = d[DIFF_W-1];
    r.num = {mag, {FRAC_SHIFT{1'b0}}};
    return r;
  endfunction

  // apply sign, saturate, add offset with saturation
  function automatic logic signed [DATA_W-1:0] map_finish(
      input logic [NUM_W-1:0] q, input logic neg,
      input logic signed [DATA_W-1:0] offset);
    logic signed [DATA_W-1:0] base;
    logic [DATA_W:0]          sum;
    if (!neg) begin
      base = (|q[NUM_W-1:DATA_W-1]) ? S32_MAX : signed'(q[DATA_W-1:0]);
    end else if ((|q[NUM_W-1:DATA_W]) || (q[DATA_W-1] && (|q[DATA_W-2:0]))) begin
      base = S32_MIN;
    end else begin
      base = signed'(DATA_W'(0) - q[DATA_W-1:0]);
    end
    sum = {base[DATA_W-1], base} + {offset[DATA_W-1], offset};
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      return sum[DATA_W] ? S32_MIN : S32_MAX;
    end
    return signed'(sum[DATA_W-1:0]);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat38(input logic [37:0] v);
    if (!((&v[37:31]) || !(|v[37:31]))) begin
      return v[37] ? S32_MIN : S32_MAX;
    end
    return signed'(v[DATA_W-1:0]);
  endfunction

endpackage

@@ hdl/jet_if.sv @@
// ----------------------------------------------------------------------------
// jet_if: channel interfaces of the Julia escape-time pixel unit
// Pixel input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface jet_pix_if;
  logic                        valid;
  logic                        ready;
  logic [jet_pkg::COORD_W-1:0] pixel_col;
  logic [jet_pkg::COORD_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface jet_res_if;
  logic                        valid;
  logic                        ready;
  logic [jet_pkg::COORD_W-1:0] out_col;
  logic [jet_pkg::COORD_W-1:0] out_row;
  logic [jet_pkg::ITER_W-1:0]  iteration_count;
  logic                        escaped;

  modport source (output valid, output out_col, output out_row,
                  output iteration_count, output escaped, input ready);
  modport sink   (input valid, input out_col, input out_row,
                  input iteration_count, input escaped, output ready);
endinterface

interface jet_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [jet_pkg::IDX_W-1:0]  index;
  logic [jet_pkg::DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/jet_div.sv @@
// ----------------------------------------------------------------------------
// jet_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module jet_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [jet_pkg::NUM_W-1:0]   num_i,
  input  logic [jet_pkg::DEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [jet_pkg::NUM_W-1:0]   quot_o
);
  import jet_pkg::*;

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic             busy;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_dif;
  logic             ge;

  assign busy    = (cnt_r != '0);
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign rem_dif = rem_sh - {1'b0, den_r};
  assign done_o  = done_r;
  assign quot_o  = num_r;

  always_ff @(posedge clk) begin
    if (start_i) begin
      num_r <= num_i;
      den_r <= den_i;
      rem_r <= '0;
    end else if (busy) begin
      rem_r <= ge ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy && (cnt_r == CNT_W'(1)) && !start_i;
      if (start_i) begin
        cnt_r <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

@@ hdl/jet_mul.sv @@
// ----------------------------------------------------------------------------
// jet_mul: shared signed multiplier
// 32 by 32 bit signed product with a registered 64 bit result.
// ----------------------------------------------------------------------------
module jet_mul (
  input  logic                              clk,
  input  logic signed [jet_pkg::DATA_W-1:0] a_i,
  input  logic signed [jet_pkg::DATA_W-1:0] b_i,
  output logic signed [2*jet_pkg::DATA_W-1:0] prod_o
);
  import jet_pkg::*;

  logic signed [2*DATA_W-1:0] prod_r;

  assign prod_o = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
  end

endmodule

@@ hdl/jet_core.sv @@
// ----------------------------------------------------------------------------
// jet_core: escape-time sequencer
// Maps a pixel through the shared divider, then iterates z = z^2 + c with
// the shared multiplier.
// ----------------------------------------------------------------------------
module jet_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  jet_pkg::cfg_t               cfg_i,
  input  logic                        start_i,
  input  logic [jet_pkg::COORD_W-1:0] pixel_col_i,
  input  logic [jet_pkg::COORD_W-1:0] pixel_row_i,
  output logic                        idle_o,
  output logic                        res_valid_o,
  input  logic                        res_take_i,
  output jet_pkg::res_t               res_o
);
  import jet_pkg::*;

  st_t                        state_r, state_nxt;
  logic [COORD_W-1:0]         col_r, col_nxt;
  logic [COORD_W-1:0]         row_r, row_nxt;
  logic signed [DATA_W-1:0]   re_r, re_nxt;
  logic signed [DATA_W-1:0]   im_r, im_nxt;
  logic signed [2*DATA_W-1:0] rr_r, rr_nxt;
  logic signed [2*DATA_W-1:0] ii_r, ii_nxt;
  logic [ITER_W-1:0]          iter_r, iter_nxt;
  logic                       esc_r, esc_nxt;
  logic                       init_r, init_nxt;

  logic [ITER_W-1:0]          limit;
  logic [ITER_W-1:0]          iter_inc;
  logic [DATA_W-1:0]          zoom_eff;
  map_num_t                   col_num, row_num, in_num;
  logic                       div_start, div_done;
  logic [NUM_W-1:0]           div_num, div_q;
  logic [DEN_W-1:0]           div_den;
  mul_sel_t                   mul_sel;
  logic signed [DATA_W-1:0]   mul_a, mul_b;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [2*DATA_W-1:0] diff;
  logic signed [DATA_W-1:0]   nre, nim;
  logic [2*DATA_W-1:0]        mag;
  logic                       escape;

  assign limit    = (cfg_i.max_iterations > ITER_CAP) ? ITER_CAP : cfg_i.max_iterations;
  assign iter_inc = iter_r + ITER_W'(1);
  assign zoom_eff = (cfg_i.zoom == '0) ? DATA_W'(1) : cfg_i.zoom;
  assign in_num   = map_num(pixel_col_i, HALF_W, SCALE_RE);
  assign col_num  = map_num(col_r, HALF_W, SCALE_RE);
  assign row_num  = map_num(row_r, HALF_H, SCALE_IM);

  assign diff   = rr_r - ii_r;
  assign nre    = sat38({{2{diff[63]}}, diff[63:28]} + {{6{cfg_i.c_real[31]}}, cfg_i.c_real});
  assign nim    = sat38({prod[63], prod[63:27]} + {{6{cfg_i.c_imag[31]}}, cfg_i.c_imag});
  assign mag    = $unsigned(rr_r) + $unsigned(prod);
  assign escape = (mag > ESC_LIMIT);

  jet_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  jet_mul u_mul (
    .clk    (clk),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start_i) state_nxt = ST_DIV_RE;
      ST_DIV_RE: if (div_done) state_nxt = ST_DIV_IM;
      ST_DIV_IM: begin
        if (div_done) begin
          state_nxt = (limit == '0) ? ST_DONE : ST_SQR;
        end
      end
      ST_SQR:    state_nxt = ST_SQI;
      ST_SQI:    state_nxt = ST_CHK;
      ST_CHK: begin
        if (init_r) begin
          state_nxt = ST_RI;
        end else if (escape || (iter_inc >= limit)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RI;
        end
      end
      ST_RI:     state_nxt = ST_NIM;
      ST_NIM:    state_nxt = ST_SQI;
      ST_DONE:   if (res_take_i) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idle_o      = (state_r == ST_IDLE);
    res_valid_o = (state_r == ST_DONE);
    div_start   = 1'b0;
    div_num     = in_num.num;
    div_den     = DEN_W'(zoom_eff) * DEN_W'(SIZE_W);
    mul_sel     = MUL_RE_IM;
    case (state_r)
      ST_IDLE: begin
        div_start = start_i;
      end
      ST_DIV_RE: begin
        div_start = div_done;
        div_num   = row_num.num;
        div_den   = DEN_W'(zoom_eff) * DEN_W'(SIZE_H);
      end
      ST_SQR, ST_NIM: mul_sel = MUL_RE_RE;
      ST_SQI:         mul_sel = MUL_IM_IM;
      default:        mul_sel = MUL_RE_IM;
    endcase
  end

  always_comb begin
    case (mul_sel)
      MUL_RE_RE: begin
        mul_a = re_r;
        mul_b = re_r;
      end
      MUL_IM_IM: begin
        mul_a = im_r;
        mul_b = im_r;
      end
      default: begin
        mul_a = re_r;
        mul_b = im_r;
      end
    endcase
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    re_nxt   = re_r;
    im_nxt   = im_r;
    rr_nxt   = rr_r;
    ii_nxt   = ii_r;
    iter_nxt = iter_r;
    esc_nxt  = esc_r;
    init_nxt = init_r;
    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          col_nxt  = pixel_col_i;
          row_nxt  = pixel_row_i;
          iter_nxt = '0;
          esc_nxt  = 1'b0;
          init_nxt = 1'b1;
        end
      end
      ST_DIV_RE: if (div_done) re_nxt = map_finish(div_q, col_num.neg, cfg_i.offset_real);
      ST_DIV_IM: if (div_done) im_nxt = map_finish(div_q, row_num.neg, cfg_i.offset_imag);
      ST_SQI:    rr_nxt = prod;
      ST_CHK: begin
        ii_nxt   = prod;
        init_nxt = 1'b0;
        if (!init_r) begin
          if (escape) begin
            esc_nxt = 1'b1;
          end else begin
            iter_nxt = iter_inc;
          end
        end
      end
      ST_RI:     re_nxt = nre;
      ST_NIM:    im_nxt = nim;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
      esc_r   <= 1'b0;
      init_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
      esc_r   <= esc_nxt;
      init_r  <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    row_r <= row_nxt;
    re_r  <= re_nxt;
    im_r  <= im_nxt;
    rr_r  <= rr_nxt;
    ii_r  <= ii_nxt;
  end

  assign res_o.out_col         = col_r;
  assign res_o.out_row         = row_r;
  assign res_o.iteration_count = iter_r;
  assign res_o.escaped         = esc_r;

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (iter_r <= limit))
    else $error("iteration count beyond limit");

  a_esc_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && esc_r) |-> (iter_r < limit))
    else $error("escape flagged at limit");

  a_init_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHK && init_r) |=> (state_r == ST_RI))
    else $error("first magnitude pass did not enter the loop");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == ST_IDLE || state_r == ST_DIV_RE))
    else $error("divider started outside mapping");

endmodule

@@ hdl/julia_escape_time_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit: Julia-set escape-time pixel unit
// Register file, result register and escape-time sequencer.
// ----------------------------------------------------------------------------
// One pixel at a time. The start point is mapped by a shared radix-2
// divider, real axis then imaginary axis, and then N iterations (up to
// max_iterations, capped at 1024) are run, each on a single shared 32x32
// multiplier. in_ch.ready is high only while no pixel is in flight; one
// finished result may wait in the output register while the next pixel is
// taken. Registers are to be written on cfg_ch, always ready, only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit (
  input  logic       clk,
  input  logic       rst_n,
  jet_pix_if.sink    in_ch,
  jet_res_if.source  out_ch,
  jet_cfg_if.sink    cfg_ch
);
  import jet_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  res_t res_r;
  res_t core_res;
  logic out_valid_r, out_valid_nxt;
  logic core_idle;
  logic core_valid;
  logic core_take;
  logic in_xfer;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = core_idle;
  assign in_xfer      = in_ch.valid && core_idle;
  assign core_take    = core_valid && (!out_valid_r || out_ch.ready);

  jet_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .start_i     (in_xfer),
    .pixel_col_i (in_ch.pixel_col),
    .pixel_row_i (in_ch.pixel_row),
    .idle_o      (core_idle),
    .res_valid_o (core_valid),
    .res_take_i  (core_take),
    .res_o       (core_res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ZOOM:        cfg_nxt.zoom           = cfg_ch.data;
        REG_OFFSET_REAL: cfg_nxt.offset_real    = signed'(cfg_ch.data);
        REG_OFFSET_IMAG: cfg_nxt.offset_imag    = signed'(cfg_ch.data);
        REG_C_REAL:      cfg_nxt.c_real         = signed'(cfg_ch.data);
        REG_C_IMAG:      cfg_nxt.c_imag         = signed'(cfg_ch.data);
        REG_MAX_ITER:    cfg_nxt.max_iterations = cfg_ch.data[ITER_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (core_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zoom           <= ZOOM_RST;
      cfg_r.offset_real    <= '0;
      cfg_r.offset_imag    <= '0;
      cfg_r.c_real         <= '0;
      cfg_r.c_imag         <= '0;
      cfg_r.max_iterations <= MAX_ITER_RST;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.out_col         = res_r.out_col;
  assign out_ch.out_row         = res_r.out_row;
  assign out_ch.iteration_count = res_r.iteration_count;
  assign out_ch.escaped         = res_r.escaped;

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(res_r)))
    else $error("stalled result changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    core_take |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    core_valid |-> !in_ch.ready)
    else $error("input ready while a result is pending in the core");

endmodule
